// ----- rtl/core/length_prefixed_hit_record_deframer_macros.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_PREFIXED_HIT_RECORD_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_HIT_RECORD_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPHD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lphd assertion failed");

// Next-cycle implication, checked outside reset.
`define LPHD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lphd assertion failed");

// Condition that must hold at every edge outside reset.
`define LPHD_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("lphd assertion failed");

`endif

// ----- rtl/core/lphd_pkg.sv -----
// Types and constants of the length-prefixed hit record deframer.
`default_nettype none

package lphd_pkg;

   // Length byte value of a hit record (11 bytes including the length byte)
   localparam logic [7:0] HIT_LEN_BYTE = 8'd10;
   // Record bytes kept in storage: bytes 1 to 9 (byte 10 arrives last)
   localparam int unsigned REC_FIRST = 1;
   localparam int unsigned REC_LAST  = 9;
   localparam int unsigned POS_W     = 8;
   localparam int unsigned RSP_W     = 80;

   // Masks used when unpacking
   localparam logic [7:0] PAYLOAD_MASK  = 8'h07;
   localparam logic [7:0] LOCATION_MASK = 8'h3f;
   localparam logic [7:0] TOT_HI_MASK   = 8'h0f;

   typedef struct packed {
      logic [7:0]  layer;
      logic [4:0]  chip_id;
      logic [2:0]  payload_code;
      logic [5:0]  location;
      logic        is_column;
      logic [7:0]  hit_time;
      logic [11:0] time_over_threshold;
      logic [31:0] fpga_time;
   } hit_type;

   // Parser result toward the output register
   typedef struct packed {
      logic    valid;
      hit_type hit;
   } hit_result_type;

endpackage

`default_nettype wire

// ----- rtl/core/lphd_parser.sv -----
// Record parser: position and length tracking, record byte storage, hit unpacking.
`default_nettype none

`include "length_prefixed_hit_record_deframer_macros.svh"

module lphd_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   byte_take,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   packet_end,
   output lphd_pkg::hit_result_type    result
);

   logic [lphd_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                 len_ff, len_in;
   logic [7:0]                 rec_ff [lphd_pkg::REC_FIRST:lphd_pkg::REC_LAST];
   logic [7:0]                 len_now;
   logic                       complete;

   // Length byte is taken from the stream at position zero
   always_comb begin
      len_now  = (pos_ff == '0) ? data_byte : len_ff;
      complete = (pos_ff >= len_now);
      len_in   = len_now;
      pos_in   = pos_ff;
      if (byte_take) begin
         if (complete || packet_end) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + lphd_pkg::POS_W'(1);
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         len_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         if (byte_take) begin
            len_ff <= len_in;
         end
      end
   end

   // Record bytes, each slot written at its own position
   always_ff @(posedge clock) begin
      for (int i = lphd_pkg::REC_FIRST; i <= lphd_pkg::REC_LAST; i++) begin
         if (byte_take && pos_ff == lphd_pkg::POS_W'(i)) begin
            rec_ff[i] <= data_byte;
         end
      end
   end

   // Unpack a completed hit record; the current byte is record byte 10
   always_comb begin
      result.valid = byte_take && complete && (len_now == lphd_pkg::HIT_LEN_BYTE);
      result.hit.layer        = rec_ff[1];
      result.hit.chip_id      = rec_ff[2][7:3];
      result.hit.payload_code = 3'(rec_ff[2] & lphd_pkg::PAYLOAD_MASK);
      result.hit.location     = 6'(rec_ff[3] & lphd_pkg::LOCATION_MASK);
      result.hit.is_column    = rec_ff[3][7];
      result.hit.hit_time     = rec_ff[4];
      result.hit.time_over_threshold =
         {4'(rec_ff[5] & lphd_pkg::TOT_HI_MASK), rec_ff[6]};
      result.hit.fpga_time    = {rec_ff[7], rec_ff[8], rec_ff[9], data_byte};
   end

   // Inside a record the position never runs past the length byte
   `LPHD_ASSERT_ALWAYS(a_pos_within_len, clock, reset, pos_ff == '0 || pos_ff <= len_ff)
   // A hit only comes out on byte 10 of an 11-byte record
   `LPHD_ASSERT_IMP(a_hit_at_byte10, clock, reset, result.valid,
      pos_ff == lphd_pkg::HIT_LEN_BYTE && len_ff == lphd_pkg::HIT_LEN_BYTE)
   // A taken end-of-packet byte restarts at a length byte
   `LPHD_ASSERT_NEXT(a_end_restarts, clock, reset, byte_take && packet_end, pos_ff == '0)

endmodule

`default_nettype wire

// ----- rtl/core/lphd_out_reg.sv -----
// Result register holding one unpacked hit for the result channel.
`default_nettype none

module lphd_out_reg (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire lphd_pkg::hit_result_type result,
   input  wire logic                   out_ready,
   output logic                        out_valid,
   output lphd_pkg::hit_type           out_hit,
   output logic                        slot_free
);

   logic               valid_ff, valid_in;
   lphd_pkg::hit_type  hit_ff;

   assign slot_free = !valid_ff || out_ready;

   // Valid flag: loaded on a parser step, cleared once taken
   always_comb begin
      if (load) begin
         valid_in = result.valid;
      end else begin
         valid_in = valid_ff && !out_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         hit_ff <= result.hit;
      end
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;

endmodule

`default_nettype wire

// ----- rtl/core/length_prefixed_hit_record_deframer.sv -----
// Top level of the length-prefixed hit record deframer.
// A hit's last record byte passes from the input register through the parser into
// the result register, which drives rsp.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or its hit is being taken in the same cycle.
// Reset (synchronous, active high) empties both registers and sets the parser
// to expect a length byte.
`default_nettype none

`include "length_prefixed_hit_record_deframer_macros.svh"

module length_prefixed_hit_record_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // packet_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] layer, [12:8] chip_id, [15:13] payload_code, [21:16] location,
   // [22] is_column, [30:23] hit_time, [42:31] time_over_threshold,
   // [74:43] fpga_time, [79:75] zero
   output logic [lphd_pkg::RSP_W-1:0] rsp_tdata
);

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;
   logic                     in_end_ff;
   logic                     slot_free;
   logic                     step;
   lphd_pkg::hit_result_type result;
   lphd_pkg::hit_type        out_hit;

   // Input register advances when the parser can step
   assign step       = in_valid_ff && slot_free;
   assign req_tready = !in_valid_ff || slot_free;

   always_comb begin
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   lphd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_take  (step),
      .data_byte  (in_byte_ff),
      .packet_end (in_end_ff),
      .result     (result)
   );

   lphd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .result    (result),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_hit   (out_hit),
      .slot_free (slot_free)
   );

   // Pack the hit, first field in the low bits
   assign rsp_tdata = {5'b0,
                       out_hit.fpga_time,
                       out_hit.time_over_threshold,
                       out_hit.hit_time,
                       out_hit.is_column,
                       out_hit.location,
                       out_hit.payload_code,
                       out_hit.chip_id,
                       out_hit.layer};

   // Input stalls only when both registers are full and the hit is not taken
   `LPHD_ASSERT_IMP(a_stall_cause, clock, reset, !req_tready,
      in_valid_ff && rsp_tvalid && !rsp_tready)
   // A new result only follows a parser step
   `LPHD_ASSERT_IMP(a_result_from_step, clock, reset, $rose(rsp_tvalid), $past(step))

endmodule

`default_nettype wire
